// ===== src/hgob_pkg.sv =====
// Package for the height grid obstacle binner: sizes, reciprocals, item and cell types.
`default_nettype none

package hgob_pkg;

    localparam int GRID_COLS   = 32;
    localparam int GRID_ROWS   = 64;
    localparam int COL_CELL_CM = 10;
    localparam int ROW_CELL_CM = 10;
    localparam int Z_STEP_CM   = 1;

    // 2 mm units per centimeter
    localparam int UNITS_PER_CM = 5;

    localparam int CELLS  = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam int IN_W  = 17;
    localparam int HZ_W  = 15;
    localparam int CNT_W = 16;
    localparam int COL_W = 5;
    localparam int ROW_W = 6;
    localparam int CFG_W = 15;
    // signed working width for quantized coordinates
    localparam int CW    = IN_W + 2;

    // divide by constant: q = (n * REC) >> SH, exact for n <= 2**IN_W
    localparam int DIV_X = UNITS_PER_CM * COL_CELL_CM;
    localparam int DIV_Y = UNITS_PER_CM * ROW_CELL_CM;
    localparam int DIV_Z = UNITS_PER_CM * Z_STEP_CM;
    localparam int SH_X  = IN_W + $clog2(DIV_X);
    localparam int SH_Y  = IN_W + $clog2(DIV_Y);
    localparam int SH_Z  = IN_W + $clog2(DIV_Z);
    localparam logic [IN_W:0] REC_X = (IN_W+1)'(((2 ** SH_X) + DIV_X - 1) / DIV_X);
    localparam logic [IN_W:0] REC_Y = (IN_W+1)'(((2 ** SH_Y) + DIV_Y - 1) / DIV_Y);
    localparam logic [IN_W:0] REC_Z = (IN_W+1)'(((2 ** SH_Z) + DIV_Z - 1) / DIV_Z);
    localparam int PX_W  = SH_X + IN_W;
    localparam int PY_W  = SH_Y + IN_W;
    localparam int PZ_W  = SH_Z + IN_W;

    // noise box near the sensor
    localparam int NOISE_COL_LO = 4;
    localparam int NOISE_COL_HI = 16;
    localparam int NOISE_ROW_HI = 6;
    localparam int NOISE_Z_HI   = 30;
    localparam int NOISE_Z_LO   = -30;

    localparam logic signed [CFG_W-1:0] Z_TOP_RST      = CFG_W'(200);
    localparam logic [CFG_W-1:0]        GROUND_THR_RST = CFG_W'(15);

    localparam logic REG_Z_TOP      = 1'b0;
    localparam logic REG_GROUND_THR = 1'b1;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_DROP     = 2'd0,
        OP_ADD      = 2'd1,
        OP_READ     = 2'd2,
        OP_READ_BAD = 2'd3
    } t_op;

    typedef struct packed {
        logic                   obs;
        logic signed [HZ_W-1:0] high;
        logic signed [HZ_W-1:0] low;
        logic [CNT_W-1:0]       count;
    } t_cell;

    // result fields, last field in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]       count;
        logic signed [HZ_W-1:0] max_height;
        logic signed [HZ_W-1:0] min_height;
        logic                   is_obstacle;
        logic [ROW_W-1:0]       cell_row;
        logic [COL_W-1:0]       cell_col;
    } t_res;

endpackage

`default_nettype wire

// ===== src/height_grid_obstacle_binner.sv =====
// Height grid obstacle binner top level: quantizer pipeline and cell store read-modify-write.
//
// Input stream (s_axis): one command per beat. tuser carries the command (0 add point,
// 1 read and clear). tdata carries x, y, z positions and the read column and row.
// Output stream (m_axis): one result beat per command, in order. tuser carries the
// accepted flag; tdata carries the touched cell: column, row, class, min/max height
// and hit count.
// Configuration: i_cfg_we writes register i_cfg_addr (0 z ceiling, 1 ground
// threshold) at the clock edge; write only while the block is idle.
// Throughput: one command per cycle while m_axis tready is high and no clearing pass
// runs. Pipeline: five register stages (abs, reciprocal multiply, decode, cell read,
// output register); the first loads on the edge that takes the input beat.
// The cell store is one 2048-entry memory with one write and one read per cycle; a
// write by the item ahead to the same cell is forwarded into the following item.
// Reset: synchronous, active low. After reset a clearing pass zeroes the store, one
// cell a cycle, over all 2048 cells; s_axis tready stays low during that pass while
// configuration writes are still taken.
// Stall: when m_axis tready is low the result holds in the output register and the
// stages behind it keep filling until the pipeline is full, then s_axis tready drops.
`default_nettype none

module height_grid_obstacle_binner
    import hgob_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: x_pos[16:0], y_pos[33:17], z_pos[50:34], read_col[55:51], read_row[61:56]
    input  wire logic [63:0]       i_s_axis_tdata,
    // tuser: command[0]
    input  wire logic [0:0]        i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // tdata: cell_col[4:0], cell_row[10:5], is_obstacle[11], min_height[26:12],
    //        max_height[41:27], hit_count[57:42]
    output logic [63:0]            o_m_axis_tdata,
    // tuser: accepted[0]
    output logic [0:0]             o_m_axis_tuser,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_addr,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    typedef struct packed {
        logic             cmd;
        logic             sx;
        logic             sy;
        logic             sz;
        logic [IN_W-1:0]  ax;
        logic [IN_W-1:0]  ay;
        logic [IN_W-1:0]  az;
        logic [COL_W-1:0] rcol;
        logic [ROW_W-1:0] rrow;
    } t_s1;

    typedef struct packed {
        logic             cmd;
        logic             sx;
        logic             sy;
        logic             sz;
        logic [IN_W-1:0]  qx;
        logic [IN_W-1:0]  qy;
        logic [IN_W-1:0]  qz;
        logic [COL_W-1:0] rcol;
        logic [ROW_W-1:0] rrow;
    } t_s2;

    typedef struct packed {
        t_op                    op;
        logic [ADDR_W-1:0]      addr;
        logic [COL_W-1:0]       col;
        logic [ROW_W-1:0]       row;
        logic signed [HZ_W-1:0] hz;
    } t_s3;

    // configuration
    logic signed [CFG_W-1:0] r_z_top;
    logic [CFG_W-1:0]        r_ground_thr;

    // clearing pass
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // pipeline
    logic  r_v1, r_v2, r_v3, r_v4, r_out_valid;
    t_s1   r_s1;
    t_s2   r_s2;
    t_s3   r_s3;
    t_s3   r_s4;
    t_res  r_out;
    logic  r_out_acc;

    // cell store
    t_cell r_mem [CELLS];
    t_cell r_rd;
    logic  r_byp_hit;
    t_cell r_byp_data;

    logic out_free, ld_out, rdy4, ld4, rdy3, ld3, rdy2, ld2, rdy1, ld1;

    // ---------------- handshake chain ----------------
    always_comb begin
        out_free = !r_out_valid || i_m_axis_tready;
        ld_out   = r_v4 && out_free;
        rdy4     = !r_v4 || out_free;
        ld4      = r_v3 && rdy4;
        rdy3     = !r_v3 || rdy4;
        ld3      = r_v2 && rdy3;
        rdy2     = !r_v2 || rdy3;
        ld2      = r_v1 && rdy2;
        rdy1     = !r_v1 || rdy2;
        o_s_axis_tready = rdy1 && !r_clr_busy;
        ld1      = i_s_axis_tvalid && o_s_axis_tready;
    end

    // ---------------- stage 1: magnitudes ----------------
    logic signed [IN_W-1:0] w_x, w_y, w_z;
    t_s1 n_s1;

    always_comb begin
        w_x = $signed(i_s_axis_tdata[16:0]);
        w_y = $signed(i_s_axis_tdata[33:17]);
        w_z = $signed(i_s_axis_tdata[50:34]);
        n_s1.cmd  = i_s_axis_tuser[0];
        n_s1.sx   = w_x[IN_W-1];
        n_s1.sy   = w_y[IN_W-1];
        n_s1.sz   = w_z[IN_W-1];
        // -(-65536) wraps to 65536, the right magnitude in unsigned
        n_s1.ax   = w_x[IN_W-1] ? IN_W'(-w_x) : IN_W'(w_x);
        n_s1.ay   = w_y[IN_W-1] ? IN_W'(-w_y) : IN_W'(w_y);
        n_s1.az   = w_z[IN_W-1] ? IN_W'(-w_z) : IN_W'(w_z);
        n_s1.rcol = i_s_axis_tdata[55:51];
        n_s1.rrow = i_s_axis_tdata[61:56];
    end

    // ---------------- stage 2: reciprocal multiply ----------------
    logic [PX_W-1:0] w_px;
    logic [PY_W-1:0] w_py;
    logic [PZ_W-1:0] w_pz;
    t_s2 n_s2;

    always_comb begin
        w_px = PX_W'(r_s1.ax) * PX_W'(REC_X);
        w_py = PY_W'(r_s1.ay) * PY_W'(REC_Y);
        w_pz = PZ_W'(r_s1.az) * PZ_W'(REC_Z);
        n_s2.cmd  = r_s1.cmd;
        n_s2.sx   = r_s1.sx;
        n_s2.sy   = r_s1.sy;
        n_s2.sz   = r_s1.sz;
        n_s2.qx   = w_px[SH_X +: IN_W];
        n_s2.qy   = w_py[SH_Y +: IN_W];
        n_s2.qz   = w_pz[SH_Z +: IN_W];
        n_s2.rcol = r_s1.rcol;
        n_s2.rrow = r_s1.rrow;
    end

    // ---------------- stage 3: cell decode and drop checks ----------------
    logic signed [CW-1:0] w_col, w_row, w_hz;
    logic                 w_off_grid, w_noise, w_ceil, w_rd_ok;
    t_s3 n_s3;

    always_comb begin
        w_col = (r_s2.sx ? -$signed(CW'(r_s2.qx)) : $signed(CW'(r_s2.qx)))
                + $signed(CW'(GRID_COLS / 2));
        w_row = r_s2.sy ? -$signed(CW'(r_s2.qy)) : $signed(CW'(r_s2.qy));
        w_hz  = r_s2.sz ? -$signed(CW'(r_s2.qz)) : $signed(CW'(r_s2.qz));

        w_off_grid = (w_col < 0) || (w_col >= $signed(CW'(GRID_COLS))) ||
                     (w_row < 0) || (w_row >= $signed(CW'(GRID_ROWS)));
        w_noise    = (w_col < $signed(CW'(NOISE_COL_HI))) &&
                     (w_col > $signed(CW'(NOISE_COL_LO))) &&
                     (w_row < $signed(CW'(NOISE_ROW_HI))) &&
                     (w_hz  < $signed(CW'(NOISE_Z_HI))) &&
                     (w_hz  > $signed(CW'(NOISE_Z_LO)));
        w_ceil     = w_hz >= CW'(r_z_top);
        w_rd_ok    = (int'(r_s2.rcol) < GRID_COLS) && (int'(r_s2.rrow) < GRID_ROWS);

        n_s3.hz = HZ_W'(w_hz);
        if (r_s2.cmd == CMD_READ) begin
            n_s3.op   = w_rd_ok ? OP_READ : OP_READ_BAD;
            n_s3.col  = r_s2.rcol;
            n_s3.row  = r_s2.rrow;
            n_s3.addr = ADDR_W'(ADDR_W'(r_s2.rcol) * ADDR_W'(GRID_ROWS)
                        + ADDR_W'(r_s2.rrow));
        end else begin
            if (w_off_grid || w_noise || w_ceil) begin
                n_s3.op  = OP_DROP;
                n_s3.col = '0;
                n_s3.row = '0;
            end else begin
                n_s3.op  = OP_ADD;
                n_s3.col = COL_W'(w_col);
                n_s3.row = ROW_W'(w_row);
            end
            n_s3.addr = ADDR_W'(ADDR_W'(w_col) * ADDR_W'(GRID_ROWS) + ADDR_W'(w_row));
        end
    end

    // ---------------- stage 4: modify and write back ----------------
    t_cell                  w_cell;
    logic signed [HZ_W-1:0] w_lo, w_hi;
    logic signed [HZ_W:0]   w_spread;
    logic                   p4_we;
    t_cell                  p4_wdata;
    t_res                   n_out;
    logic                   n_out_acc;

    always_comb begin
        w_cell = r_byp_hit ? r_byp_data : r_rd;
        if (w_cell.count == '0) begin
            w_lo = r_s4.hz;
            w_hi = r_s4.hz;
        end else begin
            w_lo = (w_cell.low  < r_s4.hz) ? w_cell.low  : r_s4.hz;
            w_hi = (w_cell.high > r_s4.hz) ? w_cell.high : r_s4.hz;
        end
        w_spread = $signed({w_hi[HZ_W-1], w_hi}) - $signed({w_lo[HZ_W-1], w_lo});

        p4_we     = 1'b0;
        p4_wdata  = '0;
        n_out     = '0;
        n_out_acc = 1'b0;
        case (r_s4.op)
            OP_ADD: begin
                p4_we          = 1'b1;
                p4_wdata.low   = w_lo;
                p4_wdata.high  = w_hi;
                p4_wdata.obs   = w_spread > $signed({1'b0, r_ground_thr});
                p4_wdata.count = (w_cell.count == CNT_MAX) ? CNT_MAX
                                 : CNT_W'(w_cell.count + 1'b1);
                n_out_acc        = 1'b1;
                n_out.cell_col   = r_s4.col;
                n_out.cell_row   = r_s4.row;
                n_out.is_obstacle = p4_wdata.obs;
                n_out.min_height = w_lo;
                n_out.max_height = w_hi;
                n_out.count      = p4_wdata.count;
            end
            OP_READ: begin
                // write back zeros: read and clear
                p4_we            = 1'b1;
                n_out_acc        = 1'b1;
                n_out.cell_col   = r_s4.col;
                n_out.cell_row   = r_s4.row;
                n_out.is_obstacle = w_cell.obs;
                n_out.min_height = w_cell.low;
                n_out.max_height = w_cell.high;
                n_out.count      = w_cell.count;
            end
            OP_READ_BAD: begin
                n_out.cell_col = r_s4.col;
                n_out.cell_row = r_s4.row;
            end
            default: begin
            end
        endcase
    end

    // ---------------- memory port ----------------
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_cell             mem_wdata;

    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = ld_out && p4_we;
            mem_waddr = r_s4.addr;
            mem_wdata = p4_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (ld4) begin
            r_rd <= r_mem[r_s3.addr];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_top      <= Z_TOP_RST;
            r_ground_thr <= GROUND_THR_RST;
            r_clr_busy   <= 1'b1;
            r_clr_addr   <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr[0] == REG_Z_TOP) begin
                    r_z_top <= $signed(i_cfg_data);
                end else begin
                    r_ground_thr <= i_cfg_data;
                end
            end
            if (r_clr_busy) begin
                r_clr_addr <= ADDR_W'(r_clr_addr + 1'b1);
                if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (rdy1) r_v1 <= ld1;
            if (rdy2) r_v2 <= ld2;
            if (rdy3) r_v3 <= ld3;
            if (rdy4) r_v4 <= ld4;
            if (out_free) r_out_valid <= ld_out;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (ld1) r_s1 <= n_s1;
        if (ld2) r_s2 <= n_s2;
        if (ld3) r_s3 <= n_s3;
        if (ld4) begin
            r_s4       <= r_s3;
            // item ahead writes the same cell on this edge: memory returns the old word
            r_byp_hit  <= mem_we && (mem_waddr == r_s3.addr);
            r_byp_data <= mem_wdata;
        end
        if (ld_out) begin
            r_out     <= n_out;
            r_out_acc <= n_out_acc;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out};
    assign o_m_axis_tuser  = r_out_acc;

    // ---------------- assertions ----------------
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_s_axis_tready)
        else $error("input beat taken during clearing pass");

    a_no_pipe_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !(r_v1 || r_v2 || r_v3 || r_v4))
        else $error("pipeline busy while store is cleared");

    a_add_is_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && r_s4.op == OP_ADD) |=> (o_m_axis_tvalid && o_m_axis_tuser[0]))
        else $error("binned point reported as dropped");

    a_obstacle_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && r_s4.op == OP_ADD) |=>
            (o_m_axis_tdata[11] == (($signed({o_m_axis_tdata[41], o_m_axis_tdata[41:27]})
              - $signed({o_m_axis_tdata[26], o_m_axis_tdata[26:12]}))
              > $signed({1'b0, $past(r_ground_thr)}))))
        else $error("obstacle class disagrees with height spread");

endmodule

`default_nettype wire
